// ----- sv/lfs_pkg.sv -----
package lfs_pkg;

   localparam int IMAGE_X_MAX = 79;
   localparam int IMAGE_Y_MAX = 52;

   localparam int MIN_LENGTH_SQ = 25;
   localparam int MIN_LOW_ROW   = 20;
   localparam int WIDTH_MIN     = 10;
   localparam int WIDTH_MAX     = 70;
   localparam int STEER_LIMIT   = 60;
   localparam int SPEED_SLOW    = 55;
   localparam int SPEED_FAST    = 75;
   localparam int SPEED_BAND    = 8;
   localparam int HOLD_FRAMES   = 4;
   localparam int RAMP_FRAMES   = 10;
   localparam int RAMP_STEP     = 5;
   localparam int RECIP_TEN     = 6554;
   localparam int DIV_STEPS     = 16;

   localparam int LANE_WIDTH_RESET   = 30;
   localparam int LAST_STEER_RESET   = 10;
   localparam int IMAGE_CENTER_RESET = 38;
   localparam int NEAR_ROW_RESET     = 48;
   localparam int FAR_ROW_RESET      = 20;
   localparam int NEAR_GAIN_RESET    = 3;
   localparam int FAR_GAIN_RESET     = 2;
   localparam int STEER_CENTER_RESET = 10;
   localparam int DEAD_BAND_RESET    = 3;
   localparam int MAX_JUMP_RESET     = 20;

   typedef enum logic [2:0] {
      CSR_IMAGE_CENTER = 3'd0,
      CSR_NEAR_ROW     = 3'd1,
      CSR_FAR_ROW      = 3'd2,
      CSR_NEAR_GAIN    = 3'd3,
      CSR_FAR_GAIN     = 3'd4,
      CSR_STEER_CENTER = 3'd5,
      CSR_DEAD_BAND    = 3'd6,
      CSR_MAX_JUMP     = 3'd7
   } csr_index_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CHECK = 9'b000000010,
      S_START = 9'b000000100,
      S_DIV   = 9'b000001000,
      S_CONS  = 9'b000010000,
      S_NEXT  = 9'b000100000,
      S_NEAR  = 9'b001000000,
      S_FAR   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic start;
      logic step;
      logic consider;
      logic next;
      logic fin_near;
      logic fin_far;
      logic fin_out;
   } cmd_type;

   typedef struct packed {
      logic vec_ok;
      logic span_ok;
      logic div_last;
      logic pass_far;
      logic eof;
      logic out_free;
   } status_type;

endpackage

// ----- sv/lfs_ctrl.sv -----
module lfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lfs_pkg::status_type status,
   output lfs_pkg::cmd_type    cmd
);

   lfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != lfs_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         lfs_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lfs_pkg::S_CHECK;
            end
         end
         lfs_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = lfs_pkg::S_START;
         end
         lfs_pkg::S_START: begin
            if (!status.vec_ok) begin
               state_in = status.eof ? lfs_pkg::S_NEAR : lfs_pkg::S_IDLE;
            end else if (status.span_ok) begin
               cmd.start = 1'b1;
               state_in  = lfs_pkg::S_DIV;
            end else begin
               state_in = lfs_pkg::S_NEXT;
            end
         end
         lfs_pkg::S_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = lfs_pkg::S_CONS;
            end
         end
         lfs_pkg::S_CONS: begin
            cmd.consider = 1'b1;
            state_in     = lfs_pkg::S_NEXT;
         end
         lfs_pkg::S_NEXT: begin
            if (!status.pass_far) begin
               cmd.next = 1'b1;
               state_in = lfs_pkg::S_START;
            end else begin
               state_in = status.eof ? lfs_pkg::S_NEAR : lfs_pkg::S_IDLE;
            end
         end
         lfs_pkg::S_NEAR: begin
            cmd.fin_near = 1'b1;
            state_in     = lfs_pkg::S_FAR;
         end
         lfs_pkg::S_FAR: begin
            cmd.fin_far = 1'b1;
            state_in    = lfs_pkg::S_OUT;
         end
         lfs_pkg::S_OUT: begin
            if (status.out_free) begin
               cmd.fin_out = 1'b1;
               state_in    = lfs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lfs_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/lfs_datapath.sv -----
module lfs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lfs_pkg::cmd_type    cmd,
   output lfs_pkg::status_type status,

   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [6:0]          csr_write_data,

   input  logic                req_has_vector,
   input  logic [7:0]          req_x_start,
   input  logic [7:0]          req_y_start,
   input  logic [7:0]          req_x_end,
   input  logic [7:0]          req_y_end,
   input  logic                req_end_of_frame,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [6:0]   rsp_steer_command,
   output logic [6:0]          rsp_drive_speed,
   output logic                rsp_near_center_valid,
   output logic signed [7:0]   rsp_near_center,
   output logic                rsp_far_center_valid,
   output logic signed [7:0]   rsp_far_center,
   output logic signed [7:0]   rsp_near_error,
   output logic signed [7:0]   rsp_far_error
);

   localparam logic signed [15:0] LIM16   = 16'(lfs_pkg::STEER_LIMIT);
   localparam logic signed [8:0]  RAMP9   = 9'(lfs_pkg::RAMP_STEP);
   localparam logic signed [8:0]  BAND9   = 9'(lfs_pkg::SPEED_BAND);
   localparam logic signed [8:0]  WMIN9   = 9'(lfs_pkg::WIDTH_MIN);
   localparam logic signed [8:0]  WMAX9   = 9'(lfs_pkg::WIDTH_MAX);
   localparam logic [3:0]         LAST_STEP = 4'(lfs_pkg::DIV_STEPS - 1);

   // configuration
   logic [6:0]        ic_ff;
   logic [5:0]        nrow_ff, frow_ff;
   logic [3:0]        ng_ff, fg_ff, db_ff;
   logic signed [6:0] sc_ff;
   logic [6:0]        mj_ff;

   // latched word
   logic       hv_ff, eof_ff;
   logic [7:0] x0_ff, y0_ff, x1_ff, y1_ff;

   // tracking state
   logic [6:0]        lw_ff;
   logic              hl_v_ff, hr_v_ff;
   logic [7:0]        hl_ff, hr_ff;
   logic signed [6:0] ls_ff;
   logic [7:0]        lost_ff;
   logic [3:0]        found_ff;
   logic [7:0]        bcol_ff [4];
   logic signed [19:0] bscore_ff [4];

   // vector work
   logic        vec_ok_ff, pass_ff;
   logic [17:0] base_ff;
   logic [7:0]  rem_ff, div_b_ff;
   logic [15:0] quo_ff;
   logic [3:0]  dcnt_ff;
   logic        neg_ff;

   // frame end work
   logic              nv_ff, fv_ff;
   logic signed [9:0] nc_ff, fc_ff, en_ff, ef_ff;

   // result register
   logic              rsp_valid_ff;
   logic signed [6:0] cmd_out_ff;
   logic [6:0]        speed_ff;
   logic              nv_out_ff, fv_out_ff;
   logic [7:0]        nc_out_ff, fc_out_ff, en_out_ff, ef_out_ff;

   function automatic logic [7:0] avg310(input logic [7:0] old, input logic [7:0] now);
      logic [11:0] num;
      logic [24:0] prod;
      num  = ({4'b0, now} << 1) + {4'b0, now} + ({4'b0, old} << 3) - {4'b0, old};
      prod = {13'b0, num} * 25'(lfs_pkg::RECIP_TEN);
      return prod[23:16];
   endfunction

   function automatic logic signed [9:0] dead(input logic signed [9:0] e,
                                              input logic [3:0] db);
      logic signed [9:0] dbs;
      dbs = $signed({6'b0, db});
      return (e >= -dbs && e <= dbs) ? 10'sd0 : e;
   endfunction

   function automatic logic [7:0] sat8(input logic signed [9:0] v);
      logic [7:0] r;
      if (v > 10'sd127) begin
         r = 8'h7f;
      end else if (v < -10'sd128) begin
         r = 8'h80;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   function automatic logic pair_ok(input logic [7:0] xl, input logic [7:0] xr);
      logic signed [8:0] w;
      w = $signed({1'b0, xr}) - $signed({1'b0, xl});
      return (w > WMIN9) && (w < WMAX9);
   endfunction

   function automatic logic pair_valid(input logic l, input logic r,
                                       input logic [7:0] xl, input logic [7:0] xr);
      return (l && r) ? pair_ok(xl, xr) : (l || r);
   endfunction

   function automatic logic signed [9:0] pair_center(input logic l, input logic r,
                                                     input logic [7:0] xl,
                                                     input logic [7:0] xr,
                                                     input logic [6:0] lw);
      logic [8:0]        sum;
      logic signed [9:0] c;
      sum = {1'b0, xl} + {1'b0, xr};
      if (l && r) begin
         c = pair_ok(xl, xr) ? $signed({2'b0, sum[8:1]}) : 10'sd0;
      end else if (l) begin
         c = $signed({2'b0, xl}) + $signed({4'b0, lw[6:1]});
      end else if (r) begin
         c = $signed({2'b0, xr}) - $signed({4'b0, lw[6:1]});
      end else begin
         c = 10'sd0;
      end
      return c;
   endfunction

   // vector check
   logic [7:0]  adx, ady, low, lo_row, hi_row, row8;
   logic [15:0] sqx, sqy;
   logic [16:0] len;
   logic        vec_ok_in;
   logic [17:0] base_in;

   always_comb begin
      adx = (x1_ff >= x0_ff) ? x1_ff - x0_ff : x0_ff - x1_ff;
      ady = (y1_ff >= y0_ff) ? y1_ff - y0_ff : y0_ff - y1_ff;
      sqx = 16'(adx) * 16'(adx);
      sqy = 16'(ady) * 16'(ady);
      len = 17'(sqx) + 17'(sqy);
      low = (y1_ff >= y0_ff) ? y1_ff : y0_ff;
      lo_row = (y1_ff >= y0_ff) ? y0_ff : y1_ff;
      hi_row = low;
      vec_ok_in = hv_ff
         && x0_ff <= 8'(lfs_pkg::IMAGE_X_MAX) && x1_ff <= 8'(lfs_pkg::IMAGE_X_MAX)
         && y0_ff <= 8'(lfs_pkg::IMAGE_Y_MAX) && y1_ff <= 8'(lfs_pkg::IMAGE_Y_MAX)
         && len >= 17'(lfs_pkg::MIN_LENGTH_SQ) && low >= 8'(lfs_pkg::MIN_LOW_ROW);
      base_in = 18'(len) + 18'({low, 2'b00});
   end

   // interpolation setup
   logic signed [8:0]  rdy, dxs, dys;
   logic signed [17:0] prod;
   logic [17:0]        prod_abs;
   logic               span_ok;

   always_comb begin
      row8 = {2'b0, pass_ff ? frow_ff : nrow_ff};
      span_ok = (y0_ff != y1_ff) && row8 >= lo_row && row8 <= hi_row;
      rdy = $signed({1'b0, row8}) - $signed({1'b0, y0_ff});
      dxs = $signed({1'b0, x1_ff}) - $signed({1'b0, x0_ff});
      dys = $signed({1'b0, y1_ff}) - $signed({1'b0, y0_ff});
      prod = rdy * dxs;
      prod_abs = prod[17] ? 18'(-prod) : 18'(prod);
   end

   // divider step
   logic [8:0] shifted, sub;
   logic       ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[15]};
      sub = shifted - {1'b0, div_b_ff};
      ge = shifted >= {1'b0, div_b_ff};
   end

   // candidate
   logic [7:0]         xc;
   logic               take [2];
   logic signed [19:0] score [2];

   always_comb begin
      logic              hv_s, side_ok, jump_ok, fnd;
      logic [7:0]        h_s, ad;
      logic signed [8:0] dif;
      logic signed [19:0] best;
      xc = neg_ff ? x0_ff - quo_ff[7:0] : x0_ff + quo_ff[7:0];
      for (int s = 0; s < 2; s++) begin
         hv_s = (s == 0) ? hl_v_ff : hr_v_ff;
         h_s  = (s == 0) ? hl_ff : hr_ff;
         side_ok = (s == 0) ? (xc < {1'b0, ic_ff}) : (xc > {1'b0, ic_ff});
         dif = $signed({1'b0, xc}) - $signed({1'b0, h_s});
         ad = dif[8] ? 8'(-dif) : dif[7:0];
         jump_ok = !hv_s || (ad <= {1'b0, mj_ff});
         score[s] = $signed({2'b0, base_ff}) - $signed(hv_s ? {9'b0, ad, 3'b0} : 20'd0);
         fnd  = pass_ff ? found_ff[2 + s] : found_ff[s];
         best = pass_ff ? bscore_ff[2 + s] : bscore_ff[s];
         take[s] = side_ok && jump_ok && (!fnd || score[s] > best);
      end
   end

   // frame end: near
   logic              nl, nr, nboth_ok, nv_in;
   logic [7:0]        lw_avg;
   logic [6:0]        lw_in;
   logic signed [9:0] nc_in;

   always_comb begin
      nl = found_ff[0];
      nr = found_ff[1];
      nboth_ok = nl && nr && pair_ok(bcol_ff[0], bcol_ff[1]);
      nv_in = pair_valid(nl, nr, bcol_ff[0], bcol_ff[1]);
      nc_in = pair_center(nl, nr, bcol_ff[0], bcol_ff[1], lw_ff);
      lw_avg = avg310({1'b0, lw_ff}, bcol_ff[1] - bcol_ff[0]);
      if (lw_avg < 8'(lfs_pkg::WIDTH_MIN)) begin
         lw_in = 7'(lfs_pkg::WIDTH_MIN);
      end else if (lw_avg > 8'(lfs_pkg::WIDTH_MAX)) begin
         lw_in = 7'(lfs_pkg::WIDTH_MAX);
      end else begin
         lw_in = lw_avg[6:0];
      end
   end

   // frame end: far
   logic              fv_in;
   logic signed [9:0] fc_in;

   always_comb begin
      fv_in = pair_valid(found_ff[2], found_ff[3], bcol_ff[2], bcol_ff[3]);
      fc_in = pair_center(found_ff[2], found_ff[3], bcol_ff[2], bcol_ff[3], lw_ff);
   end

   // steering
   logic signed [14:0] pn, pf;
   logic signed [15:0] sum;
   logic signed [6:0]  cmd_clamp, ls_next, cmd_final;
   logic signed [8:0]  ls9, sc9, cmd9;
   logic [7:0]         lost_new;
   logic               out_free;

   always_comb begin
      pn = $signed({1'b0, ng_ff}) * en_ff;
      pf = $signed({1'b0, fg_ff}) * ef_ff;
      sum = 16'(sc_ff) + 16'(pn) + 16'(pf);
      if (sum > LIM16) begin
         cmd_clamp = 7'(lfs_pkg::STEER_LIMIT);
      end else if (sum < -LIM16) begin
         cmd_clamp = 7'(-lfs_pkg::STEER_LIMIT);
      end else begin
         cmd_clamp = sum[6:0];
      end
      lost_new = (&lost_ff) ? lost_ff : lost_ff + 8'd1;
      ls9 = 9'(ls_ff);
      sc9 = 9'(sc_ff);
      if (lost_new <= 8'(lfs_pkg::HOLD_FRAMES)) begin
         ls_next = ls_ff;
      end else if (lost_new <= 8'(lfs_pkg::RAMP_FRAMES)) begin
         if (ls9 > sc9 + RAMP9) begin
            ls_next = 7'(ls9 - RAMP9);
         end else if (ls9 < sc9 - RAMP9) begin
            ls_next = 7'(ls9 + RAMP9);
         end else begin
            ls_next = sc_ff;
         end
      end else begin
         ls_next = sc_ff;
      end
      cmd_final = nv_ff ? cmd_clamp : ls_next;
      cmd9 = 9'(cmd_final);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign status.vec_ok   = vec_ok_ff;
   assign status.span_ok  = span_ok;
   assign status.div_last = (dcnt_ff == LAST_STEP);
   assign status.pass_far = pass_ff;
   assign status.eof      = eof_ff;
   assign status.out_free = out_free;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff   <= 7'(lfs_pkg::IMAGE_CENTER_RESET);
         nrow_ff <= 6'(lfs_pkg::NEAR_ROW_RESET);
         frow_ff <= 6'(lfs_pkg::FAR_ROW_RESET);
         ng_ff   <= 4'(lfs_pkg::NEAR_GAIN_RESET);
         fg_ff   <= 4'(lfs_pkg::FAR_GAIN_RESET);
         sc_ff   <= 7'(lfs_pkg::STEER_CENTER_RESET);
         db_ff   <= 4'(lfs_pkg::DEAD_BAND_RESET);
         mj_ff   <= 7'(lfs_pkg::MAX_JUMP_RESET);
         lw_ff   <= 7'(lfs_pkg::LANE_WIDTH_RESET);
         hl_v_ff <= 1'b0;
         hr_v_ff <= 1'b0;
         ls_ff   <= 7'(lfs_pkg::LAST_STEER_RESET);
         lost_ff <= 8'd0;
         found_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               lfs_pkg::CSR_IMAGE_CENTER: ic_ff   <= csr_write_data;
               lfs_pkg::CSR_NEAR_ROW:     nrow_ff <= csr_write_data[5:0];
               lfs_pkg::CSR_FAR_ROW:      frow_ff <= csr_write_data[5:0];
               lfs_pkg::CSR_NEAR_GAIN:    ng_ff   <= csr_write_data[3:0];
               lfs_pkg::CSR_FAR_GAIN:     fg_ff   <= csr_write_data[3:0];
               lfs_pkg::CSR_STEER_CENTER: sc_ff   <= $signed(csr_write_data);
               lfs_pkg::CSR_DEAD_BAND:    db_ff   <= csr_write_data[3:0];
               lfs_pkg::CSR_MAX_JUMP:     mj_ff   <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.consider) begin
            for (int s = 0; s < 2; s++) begin
               if (take[s]) begin
                  found_ff[{pass_ff, 1'(s)}] <= 1'b1;
               end
            end
         end
         if (cmd.fin_near) begin
            if (nboth_ok) begin
               lw_ff <= lw_in;
            end
            if ((nl && !nr) || nboth_ok) begin
               hl_v_ff <= 1'b1;
            end
            if ((nr && !nl) || nboth_ok) begin
               hr_v_ff <= 1'b1;
            end
         end
         if (cmd.fin_out) begin
            found_ff <= 4'd0;
            if (nv_ff) begin
               ls_ff   <= cmd_clamp;
               lost_ff <= 8'd0;
            end else begin
               ls_ff   <= ls_next;
               lost_ff <= lost_new;
               if (lost_new > 8'(lfs_pkg::RAMP_FRAMES)) begin
                  hl_v_ff <= 1'b0;
                  hr_v_ff <= 1'b0;
               end
            end
         end
         if (cmd.fin_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hv_ff  <= req_has_vector;
         x0_ff  <= req_x_start;
         y0_ff  <= req_y_start;
         x1_ff  <= req_x_end;
         y1_ff  <= req_y_end;
         eof_ff <= req_end_of_frame;
      end
      if (cmd.check) begin
         vec_ok_ff <= vec_ok_in;
         base_ff   <= base_in;
         pass_ff   <= 1'b0;
      end
      if (cmd.next) begin
         pass_ff <= 1'b1;
      end
      if (cmd.start) begin
         rem_ff   <= 8'd0;
         quo_ff   <= prod_abs[15:0];
         div_b_ff <= ady;
         neg_ff   <= prod[17] ^ dys[8];
         dcnt_ff  <= 4'd0;
      end
      if (cmd.step) begin
         rem_ff  <= ge ? sub[7:0] : shifted[7:0];
         quo_ff  <= {quo_ff[14:0], ge};
         dcnt_ff <= dcnt_ff + 4'd1;
      end
      if (cmd.consider) begin
         for (int s = 0; s < 2; s++) begin
            if (take[s]) begin
               bcol_ff[{pass_ff, 1'(s)}]   <= xc;
               bscore_ff[{pass_ff, 1'(s)}] <= score[s];
            end
         end
      end
      if (cmd.fin_near) begin
         if ((nl && !nr) || nboth_ok) begin
            hl_ff <= hl_v_ff ? avg310(hl_ff, bcol_ff[0]) : bcol_ff[0];
         end
         if ((nr && !nl) || nboth_ok) begin
            hr_ff <= hr_v_ff ? avg310(hr_ff, bcol_ff[1]) : bcol_ff[1];
         end
         nv_ff <= nv_in;
         nc_ff <= nc_in;
         en_ff <= nv_in ? dead(nc_in - $signed({3'b0, ic_ff}), db_ff) : 10'sd0;
      end
      if (cmd.fin_far) begin
         fv_ff <= fv_in;
         fc_ff <= fc_in;
         ef_ff <= (nv_ff && fv_in) ? dead(fc_in - $signed({3'b0, ic_ff}), db_ff) : 10'sd0;
      end
      if (cmd.fin_out) begin
         cmd_out_ff <= cmd_final;
         speed_ff   <= (cmd9 >= sc9 - BAND9 && cmd9 <= sc9 + BAND9) ?
                       7'(lfs_pkg::SPEED_SLOW) : 7'(lfs_pkg::SPEED_FAST);
         nv_out_ff  <= nv_ff;
         nc_out_ff  <= sat8(nc_ff);
         fv_out_ff  <= fv_ff;
         fc_out_ff  <= sat8(fc_ff);
         en_out_ff  <= sat8(en_ff);
         ef_out_ff  <= sat8(ef_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_steer_command     = cmd_out_ff;
   assign rsp_drive_speed       = speed_ff;
   assign rsp_near_center_valid = nv_out_ff;
   assign rsp_near_center       = $signed(nc_out_ff);
   assign rsp_far_center_valid  = fv_out_ff;
   assign rsp_far_center        = $signed(fc_out_ff);
   assign rsp_near_error        = $signed(en_out_ff);
   assign rsp_far_error         = $signed(ef_out_ff);

endmodule

// ----- sv/lane_follow_steering.sv -----
// Lane following steering: takes one line vector word per frame step and returns one steering
// word at each end of frame. A usable vector is interpolated for each of the near and far
// rows it spans (one shared 16-step serial divider does the interpolation). An end of frame
// then forms the centres and the command. The result waits in an output register; a following
// word is taken meanwhile, and only another end of frame waits for it to be taken.
module lane_follow_steering (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_write_data,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_has_vector,
   input  logic [7:0]        req_x_start,
   input  logic [7:0]        req_y_start,
   input  logic [7:0]        req_x_end,
   input  logic [7:0]        req_y_end,
   input  logic              req_end_of_frame,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [6:0] rsp_steer_command,
   output logic [6:0]        rsp_drive_speed,
   output logic              rsp_near_center_valid,
   output logic signed [7:0] rsp_near_center,
   output logic              rsp_far_center_valid,
   output logic signed [7:0] rsp_far_center,
   output logic signed [7:0] rsp_near_error,
   output logic signed [7:0] rsp_far_error
);

   lfs_pkg::cmd_type    cmd;
   lfs_pkg::status_type status;

   lfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfs_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_has_vector        (req_has_vector),
      .req_x_start           (req_x_start),
      .req_y_start           (req_y_start),
      .req_x_end             (req_x_end),
      .req_y_end             (req_y_end),
      .req_end_of_frame      (req_end_of_frame),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_steer_command     (rsp_steer_command),
      .rsp_drive_speed       (rsp_drive_speed),
      .rsp_near_center_valid (rsp_near_center_valid),
      .rsp_near_center       (rsp_near_center),
      .rsp_far_center_valid  (rsp_far_center_valid),
      .rsp_far_center        (rsp_far_center),
      .rsp_near_error        (rsp_near_error),
      .rsp_far_error         (rsp_far_error)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_out |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while waiting");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("not busy after taking a word");

   a_div_then_consider: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.div_last) |=> cmd.consider)
      else $error("division end not followed by candidate update");

endmodule
